// ===== hw/rtl/stride_process_scheduler_top_defines.svh =====
// Assertion helpers for the scheduler controller RTL.
`ifndef STRIDE_PROCESS_SCHEDULER_TOP_DEFINES_SVH
`define STRIDE_PROCESS_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SPS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SPS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sps_pkg.sv =====
package sps_pkg;

  // Fixed field widths.
  localparam int KIND_W    = 2;
  localparam int IN_PID_W  = 16;
  localparam int OUT_PID_W = 16;
  localparam int RATE_W    = 8;
  localparam int POL_W     = 3;
  localparam int STAMP_W   = 32;
  localparam int PASS_W    = 32;
  localparam int STRIDE_W  = 17;
  localparam int SHARE_W   = 7;

  // Parameter defaults.
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_PID_BITS = 16;

  // Arithmetic constants.
  localparam logic [STRIDE_W-1:0] FULL_SCALE = 17'd100000;
  localparam int PERCENT = 100;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCHED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REQ   = 2'd3;

  // Policies.
  localparam logic [POL_W-1:0] POL_FIRST  = 3'd0;
  localparam logic [POL_W-1:0] POL_OLDEST = 3'd1;
  localparam logic [POL_W-1:0] POL_NEWEST = 3'd2;
  localparam logic [POL_W-1:0] POL_ROUND  = 3'd3;
  localparam logic [POL_W-1:0] POL_STRIDE = 3'd4;

  // Divider jobs.
  localparam logic [1:0] DIV_EACH = 2'd0;
  localparam logic [1:0] DIV_FAIR = 2'd1;
  localparam logic [1:0] DIV_REQ  = 2'd2;

  // Per-entry fields besides the process id.
  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [PASS_W-1:0]   pass;
    logic [STRIDE_W-1:0] stride;
    logic [SHARE_W-1:0]  share;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       scan_go;
    logic       scan_upd;
    logic       wr_new;
    logic       clr_valid;
    logic       sched_take;
    logic       div_go;
    logic [1:0] div_sel;
    logic       out_load;
    logic       out_ok;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              scan_done;
    logic              div_done;
    logic              start_ok;
    logic              end_ok;
    logic              req_ok;
    logic              sched_ok;
    logic              stride_pol;
    logic [KIND_W-1:0] kind;
  } sts_t;

endpackage

// ===== hw/rtl/stride_process_scheduler_top.sv =====
// Process table scheduler: start, end, schedule and rate-request items each give one result
// (ok, chosen_pid). Every item walks the table once, one entry per cycle through the entry
// memory read port. Under the stride policy a successful start or end, or a granted request,
// also runs three divisions on the shared serial divider and a second walk that rewrites
// each valid entry. One item is in work at a time; a finished result waits in the output
// register while the next item is taken. The policy register should be written only while
// the block is idle.
module stride_process_scheduler_top #(
  parameter int ENTRIES  = sps_pkg::DEF_ENTRIES,
  parameter int PID_BITS = sps_pkg::DEF_PID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sps_pkg::KIND_W-1:0]    in_kind,
  input  logic [sps_pkg::IN_PID_W-1:0]  in_pid,
  input  logic [sps_pkg::RATE_W-1:0]    in_rate,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [sps_pkg::OUT_PID_W-1:0] out_chosen_pid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sps_pkg::POL_W-1:0]     cfg_policy
);
  import sps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ok    (out_ok),
    .sts       (sts),
    .cmd       (cmd)
  );

  sps_dp #(
    .ENTRIES  (ENTRIES),
    .PID_BITS (PID_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_pid         (in_pid),
    .in_rate        (in_rate),
    .cfg_wr         (cfg_valid),
    .cfg_policy     (cfg_policy),
    .cmd            (cmd),
    .sts            (sts),
    .out_chosen_pid (out_chosen_pid)
  );

endmodule

// ===== hw/rtl/sps_ram.sv =====
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sps_div.sv =====
module sps_div #(
  parameter int DVW = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sps_pkg::STRIDE_W-1:0] numer,
  input  logic [DVW-1:0]               denom,
  output logic                         done,
  output logic [sps_pkg::STRIDE_W-1:0] quot
);
  import sps_pkg::*;

  localparam int STEP_W = $clog2(STRIDE_W);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [STRIDE_W-1:0] num_r;
  logic [STRIDE_W-1:0] q_r;
  logic [DVW-1:0]    rem_r;
  logic [DVW-1:0]    den_r;
  logic              done_r;
  logic [DVW:0]      trial;
  logic              fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, num_r[STRIDE_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(STRIDE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // Payload of the division.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[STRIDE_W-2:0], 1'b0};
      q_r   <= {q_r[STRIDE_W-2:0], fits};
      rem_r <= fits ? DVW'(trial - {1'b0, den_r}) : trial[DVW-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hw/rtl/sps_dp.sv =====
module sps_dp #(
  parameter int ENTRIES  = sps_pkg::DEF_ENTRIES,
  parameter int PID_BITS = sps_pkg::DEF_PID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sps_pkg::KIND_W-1:0]    in_kind,
  input  logic [sps_pkg::IN_PID_W-1:0]  in_pid,
  input  logic [sps_pkg::RATE_W-1:0]    in_rate,
  input  logic                          cfg_wr,
  input  logic [sps_pkg::POL_W-1:0]     cfg_policy,
  input  sps_pkg::cmd_t                 cmd,
  output sps_pkg::sts_t                 sts,
  output logic [sps_pkg::OUT_PID_W-1:0] out_chosen_pid
);
  import sps_pkg::*;

  localparam int IDXW   = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int TW     = $clog2(PERCENT * ENTRIES + 1) + 1;
  localparam int DVW    = (CW > SHARE_W) ? CW : SHARE_W;
  localparam int EW     = $bits(entry_t);
  localparam int WORD_W = PID_BITS + EW;

  // Item and control registers.
  logic [POL_W-1:0]    policy_r;
  logic [KIND_W-1:0]   kind_r;
  logic [PID_BITS-1:0] pid_r;
  logic [RATE_W-1:0]   rate_r;
  logic [STAMP_W-1:0]  cnt_r;
  logic [IDXW-1:0]     rp_r;
  logic [ENTRIES-1:0]  valid_r;

  // Scan sequencing.
  logic            run_r;
  logic [IDXW-1:0] sidx_r;
  logic            pv_r;
  logic [IDXW-1:0] pidx_r;
  logic            upd_r;

  // Gathered statistics.
  logic                free_f_r, mat_f_r, any_r, fst_f_r, ge_f_r, best_f_r;
  logic [IDXW-1:0]     free_idx_r, mat_idx_r, fst_idx_r, ge_idx_r, best_idx_r;
  logic [SHARE_W-1:0]  mat_share_r;
  logic [CW-1:0]       call_r, cnm_r;
  logic [TW-1:0]       tall_r, tnm_r;
  logic [PID_BITS-1:0] fst_pid_r, ge_pid_r, best_pid_r;
  entry_t              best_e_r;

  // Division results.
  logic [1:0]          dsel_r;
  logic [SHARE_W-1:0]  each_r;
  logic [STRIDE_W-1:0] fair_r, reqs_r;

  logic [WORD_W-1:0]   rdata;
  logic [PID_BITS-1:0] rd_pid;
  entry_t              rd_e, upd_e, sch_e;
  logic                rd_v, rd_match, better;
  logic [STAMP_W-1:0]  pid_ext;
  logic [STAMP_W-1:0]  chosen_ext;
  logic [PID_BITS-1:0] chosen_pid;
  logic [IDXW-1:0]     chosen_idx;
  logic                sched_ok;
  logic [TW-1:0]       taken_sel;
  logic [CW-1:0]       count_sel;
  logic [SHARE_W-1:0]  left;
  logic [STRIDE_W-1:0] div_num, div_q;
  logic [DVW-1:0]      div_den;
  logic                div_done;
  logic [STRIDE_W-1:0] fair_eff;
  logic [PASS_W:0]     pass_sum;
  logic                ram_we;
  logic [IDXW-1:0]     ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                scan_done;

  assign pid_ext = STAMP_W'(in_pid);

  // Policy register and item capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_STRIDE;
      cnt_r    <= '0;
      rp_r     <= '0;
      valid_r  <= '0;
    end else begin
      if (cfg_wr) begin
        policy_r <= cfg_policy;
      end
      if (cmd.load && in_kind == KIND_START) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.wr_new) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.clr_valid) begin
        valid_r[mat_idx_r] <= 1'b0;
      end
      if (cmd.sched_take && policy_r == POL_ROUND) begin
        rp_r <= (chosen_idx == IDXW'(ENTRIES - 1)) ? '0 : chosen_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      pid_r  <= pid_ext[PID_BITS-1:0];
      rate_r <= in_rate;
    end
  end

  // Table walk: one read issued per cycle, its data handled in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pv_r  <= 1'b0;
      upd_r <= 1'b0;
    end else begin
      pv_r <= run_r;
      if (cmd.scan_go) begin
        run_r <= 1'b1;
        upd_r <= cmd.scan_upd;
      end else if (run_r && sidx_r == IDXW'(ENTRIES - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= sidx_r;
    if (cmd.scan_go) begin
      sidx_r <= '0;
    end else if (run_r) begin
      sidx_r <= sidx_r + 1'b1;
    end
  end

  assign scan_done = pv_r && pidx_r == IDXW'(ENTRIES - 1);

  // Entry store.
  sps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (sidx_r),
    .rdata (rdata)
  );

  assign rd_pid   = rdata[WORD_W-1 -: PID_BITS];
  assign rd_e     = entry_t'(rdata[EW-1:0]);
  assign rd_v     = valid_r[pidx_r];
  assign rd_match = rd_pid == pid_r;

  // Ordering of a candidate against the current best.
  always_comb begin
    case (policy_r)
      POL_OLDEST: better = rd_e.stamp < best_e_r.stamp;
      POL_NEWEST: better = rd_e.stamp > best_e_r.stamp;
      default:    better = rd_e.pass < best_e_r.pass;
    endcase
  end

  // Gather pass statistics.
  always_ff @(posedge clk) begin
    if (cmd.scan_go && !cmd.scan_upd) begin
      free_f_r <= 1'b0;
      mat_f_r  <= 1'b0;
      any_r    <= 1'b0;
      fst_f_r  <= 1'b0;
      ge_f_r   <= 1'b0;
      best_f_r <= 1'b0;
      call_r   <= '0;
      cnm_r    <= '0;
      tall_r   <= '0;
      tnm_r    <= '0;
    end else if (pv_r && !upd_r) begin
      if (!rd_v) begin
        if (!free_f_r) begin
          free_f_r   <= 1'b1;
          free_idx_r <= pidx_r;
        end
      end else begin
        if (rd_match) begin
          any_r <= 1'b1;
          if (!mat_f_r) begin
            mat_f_r     <= 1'b1;
            mat_idx_r   <= pidx_r;
            mat_share_r <= rd_e.share;
          end
        end
        if (rd_e.share == '0) begin
          call_r <= call_r + 1'b1;
        end else begin
          tall_r <= tall_r + TW'(rd_e.share);
        end
        if (!rd_match) begin
          if (rd_e.share == '0) begin
            cnm_r <= cnm_r + 1'b1;
          end else begin
            tnm_r <= tnm_r + TW'(rd_e.share);
          end
        end
        if (!fst_f_r) begin
          fst_f_r   <= 1'b1;
          fst_idx_r <= pidx_r;
          fst_pid_r <= rd_pid;
        end
        if (!ge_f_r && pidx_r >= rp_r) begin
          ge_f_r   <= 1'b1;
          ge_idx_r <= pidx_r;
          ge_pid_r <= rd_pid;
        end
        if (!best_f_r || better) begin
          best_f_r   <= 1'b1;
          best_idx_r <= pidx_r;
          best_pid_r <= rd_pid;
          best_e_r   <= rd_e;
        end
      end
    end
  end

  // Share totals after the change this item makes.
  always_comb begin
    case (kind_r)
      KIND_START: begin
        taken_sel = tall_r;
        count_sel = call_r + 1'b1;
      end
      KIND_END: begin
        if (mat_share_r == '0) begin
          taken_sel = tall_r;
          count_sel = call_r - 1'b1;
        end else begin
          taken_sel = tall_r - TW'(mat_share_r);
          count_sel = call_r;
        end
      end
      default: begin
        taken_sel = tnm_r + TW'(rate_r);
        count_sel = cnm_r;
      end
    endcase
    left = (taken_sel >= TW'(PERCENT)) ? '0 : SHARE_W'(TW'(PERCENT) - taken_sel);
  end

  // Divider operands. The fair-share division starts in the cycle the per-entry
  // share comes out of the divider, so it takes that share straight from the quotient.
  always_comb begin
    case (cmd.div_sel)
      DIV_EACH: begin
        div_num = STRIDE_W'(left);
        div_den = DVW'(count_sel);
      end
      DIV_FAIR: begin
        div_num = FULL_SCALE;
        div_den = DVW'(div_q[SHARE_W-1:0]);
      end
      default: begin
        div_num = FULL_SCALE;
        div_den = DVW'(rate_r[SHARE_W-1:0]);
      end
    endcase
  end

  sps_div #(
    .DVW (DVW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .numer (div_num),
    .denom (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dsel_r <= cmd.div_sel;
    end
    if (div_done) begin
      case (dsel_r)
        DIV_EACH: each_r <= div_q[SHARE_W-1:0];
        DIV_FAIR: fair_r <= div_q;
        default:  reqs_r <= div_q;
      endcase
    end
  end

  assign fair_eff = (each_r == '0) ? FULL_SCALE : fair_r;

  // Update pass: clear passes, refresh strides, place request and new entry.
  always_comb begin
    upd_e      = rd_e;
    upd_e.pass = '0;
    if (kind_r == KIND_REQ && rd_match) begin
      upd_e.share  = rate_r[SHARE_W-1:0];
      upd_e.stride = reqs_r;
      upd_e.pass   = PASS_W'(reqs_r);
    end else if (rd_e.share == '0) begin
      upd_e.stride = fair_eff;
    end
    if (kind_r == KIND_START && pidx_r == free_idx_r) begin
      upd_e.pass = PASS_W'(upd_e.stride);
    end
  end

  // Winner of a schedule decision.
  always_comb begin
    case (policy_r)
      POL_FIRST: begin
        chosen_pid = fst_pid_r;
        chosen_idx = fst_idx_r;
      end
      POL_ROUND: begin
        chosen_pid = ge_f_r ? ge_pid_r : fst_pid_r;
        chosen_idx = ge_f_r ? ge_idx_r : fst_idx_r;
      end
      default: begin
        chosen_pid = best_pid_r;
        chosen_idx = best_idx_r;
      end
    endcase
    case (policy_r)
      POL_FIRST, POL_ROUND:               sched_ok = fst_f_r;
      POL_OLDEST, POL_NEWEST, POL_STRIDE: sched_ok = best_f_r;
      default:                            sched_ok = 1'b0;
    endcase
  end

  // Saturating pass advance of the stride winner.
  always_comb begin
    pass_sum = {1'b0, best_e_r.pass} + (PASS_W + 1)'(best_e_r.stride);
    sch_e    = best_e_r;
    sch_e.pass = pass_sum[PASS_W] ? '1 : pass_sum[PASS_W-1:0];
  end

  // Store write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx_r;
    ram_wdata = {rd_pid, upd_e};
    if (cmd.wr_new) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx_r;
      ram_wdata = {pid_r, cnt_r, {(EW - STAMP_W){1'b0}}};
    end else if (cmd.sched_take && policy_r == POL_STRIDE) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
      ram_wdata = {best_pid_r, sch_e};
    end else if (pv_r && upd_r && rd_v) begin
      ram_we    = 1'b1;
    end
  end

  // Result payload register.
  assign chosen_ext = STAMP_W'(chosen_pid);
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chosen_pid <= (cmd.out_ok && kind_r == KIND_SCHED) ?
                        chosen_ext[OUT_PID_W-1:0] : '0;
    end
  end

  assign sts.scan_done  = scan_done;
  assign sts.div_done   = div_done;
  assign sts.start_ok   = free_f_r;
  assign sts.end_ok     = mat_f_r;
  assign sts.req_ok     = policy_r == POL_STRIDE && rate_r != '0 && any_r &&
                          (tnm_r + TW'(rate_r)) <= TW'(PERCENT);
  assign sts.sched_ok   = sched_ok;
  assign sts.stride_pol = policy_r == POL_STRIDE;
  assign sts.kind       = kind_r;

endmodule

// ===== hw/rtl/sps_ctrl.sv =====
`include "stride_process_scheduler_top_defines.svh"

module sps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_ok,
  input  sps_pkg::sts_t sts,
  output sps_pkg::cmd_t cmd
);
  import sps_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GATHER = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] dstep_r, dstep_nxt;
  logic       ok_r, ok_nxt;
  logic       out_valid_r, out_ok_r;

  // Sequencer for one item.
  always_comb begin
    state_nxt = state_r;
    dstep_nxt = dstep_r;
    ok_nxt    = ok_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.scan_go = 1'b1;
          state_nxt   = S_GATHER;
        end
      end
      S_GATHER: begin
        if (sts.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ok_nxt    = 1'b0;
        state_nxt = S_RESP;
        dstep_nxt = '0;
        case (sts.kind)
          KIND_START: begin
            if (sts.start_ok) begin
              ok_nxt     = 1'b1;
              cmd.wr_new = 1'b1;
              if (sts.stride_pol) begin
                cmd.div_go = 1'b1;
                state_nxt  = S_DIV;
              end
            end
          end
          KIND_END: begin
            if (sts.end_ok) begin
              ok_nxt        = 1'b1;
              cmd.clr_valid = 1'b1;
              if (sts.stride_pol) begin
                cmd.div_go = 1'b1;
                state_nxt  = S_DIV;
              end
            end
          end
          KIND_SCHED: begin
            if (sts.sched_ok) begin
              ok_nxt         = 1'b1;
              cmd.sched_take = 1'b1;
            end
          end
          default: begin
            if (sts.req_ok) begin
              ok_nxt     = 1'b1;
              cmd.div_go = 1'b1;
              state_nxt  = S_DIV;
            end
          end
        endcase
        cmd.div_sel = DIV_EACH;
      end
      S_DIV: begin
        cmd.div_sel = dstep_r + 1'b1;
        if (sts.div_done) begin
          if (dstep_r == DIV_REQ) begin
            cmd.scan_go  = 1'b1;
            cmd.scan_upd = 1'b1;
            state_nxt    = S_UPDATE;
          end else begin
            cmd.div_go = 1'b1;
            dstep_nxt  = dstep_r + 1'b1;
          end
        end
      end
      S_UPDATE: begin
        if (sts.scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_ok   = ok_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dstep_r     <= '0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dstep_r <= dstep_nxt;
      ok_r    <= ok_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result flag register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok_r <= ok_r;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;

  `SPS_ASSERT_IMP(a_one_write, 1'b1, $onehot0({cmd.wr_new, cmd.clr_valid, cmd.sched_take}), "table writes collide")
  `SPS_ASSERT_IMP(a_div_phase, sts.div_done, state_r == S_DIV, "division finished outside its phase")
  `SPS_ASSERT_IMP(a_scan_phase, sts.scan_done, state_r == S_GATHER || state_r == S_UPDATE, "table walk outside a scan phase")
  `SPS_ASSERT_NXT(a_upd_resp, state_r == S_UPDATE && sts.scan_done, state_r == S_RESP && ok_r, "update pass did not end in a good result")

endmodule
